// ===== rtl/svi_pkg.sv =====
// shared types and constants for the streamfunction velocity interpolator
// no dependencies; used by every module of the block except svi_ram
package svi_pkg;

	// grid geometry
	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;
	localparam int IDX_W    = 6;
	localparam int NODE_BANK_DEPTH = MAX_COLS * MAX_ROWS / 4;
	localparam int CELL_BANK_DEPTH = MAX_COLS * MAX_ROWS;

	// output queue depth, bounds queries in flight
	localparam int OFIFO_DEPTH = 16;
	localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);

	// operation codes
	localparam logic [1:0] OP_WR_NODE = 2'd0;
	localparam logic [1:0] OP_WR_CELL = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	// register indexes
	localparam logic [1:0] REG_LAYOUT = 2'd0;
	localparam logic [1:0] REG_INV    = 2'd1;
	localparam logic [1:0] REG_COLS   = 2'd2;
	localparam logic [1:0] REG_ROWS   = 2'd3;

	typedef struct packed {
		logic              we_node;
		logic              we_cell;
		logic              rd;
		logic [IDX_W-1:0]  wcol;
		logic [IDX_W-1:0]  wrow;
		logic [1:0]        wcor;
		logic [31:0]       wdata;
		logic [IDX_W-1:0]  qcol;
		logic [IDX_W-1:0]  qrow;
	} store_req_t;

	typedef struct packed {
		logic        sat;
		logic [31:0] vel_y;
		logic [31:0] vel_x;
	} out_word_t;

endpackage

// ===== rtl/streamfunction_velocity_interp.sv =====
// top level of the streamfunction velocity interpolator
// depends on svi_pkg, svi_store, svi_calc, svi_ofifo
//
// Takes one input word per cycle unless stalled, writes and queries alike.
// Writes land in the node store (four parity banks) or the corner store (one
// bank per corner) in the cycle after acceptance; a query reads all four cell
// corners at once from the banks, and its result word passes through the calc
// stages into a 16-word queue, where results wait; the input stalls only when 16
// queries are in flight or queued, so with the output taking words the block
// sustains one item per cycle. No clearing pass: entries must be written
// before they are queried.
module streamfunction_velocity_interp (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// col_index[5:0] row_index[11:6] corner[13:12] stream_value[45:14]
	// pos_x[77:46] pos_y[109:78], zero pad to 111
	input  logic [111:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]   s_tuser,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// vel_x[31:0] vel_y[63:32]
	output logic [63:0]  m_tdata,
	// saturated[0]
	output logic [0:0]   m_tuser
);

	logic        layout_q;
	logic [31:0] inv_q;
	logic [6:0]  cols_q, rows_q;
	logic [svi_pkg::OFIFO_AW:0] inflight_q;
	logic        acc, take;

	logic        vld_s1;
	logic [1:0]  op_s1;
	logic [5:0]  col_s1, row_s1;
	logic [1:0]  cor_s1;
	logic [31:0] sv_s1;
	logic signed [64:0] px_s1, py_s1;
	logic [15:0] fx_s2, fy_s2;

	svi_pkg::store_req_t req;
	logic        vld_s2, vld_s7;
	logic [31:0] v_s2 [4];
	svi_pkg::out_word_t res_s7, head;
	logic        nonempty;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= 1'b0;
			inv_q    <= 32'd65536;
			cols_q   <= 7'd64;
			rows_q   <= 7'd64;
		end else if (cfg_valid) begin
			case (cfg_index)
				svi_pkg::REG_LAYOUT: layout_q <= cfg_data[0];
				svi_pkg::REG_INV:    inv_q    <= cfg_data;
				svi_pkg::REG_COLS:   cols_q   <= cfg_data[6:0];
				svi_pkg::REG_ROWS:   rows_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// credit for queries in flight
	assign s_tready = (inflight_q < (svi_pkg::OFIFO_AW+1)'(svi_pkg::OFIFO_DEPTH));
	assign acc      = s_tvalid && s_tready;
	assign take     = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q
				+ (svi_pkg::OFIFO_AW+1)'(acc && (s_tuser == svi_pkg::OP_QUERY))
				- (svi_pkg::OFIFO_AW+1)'(take);
		end
	end

	// stage 1: capture and scale position by reciprocal cell size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= s_tuser;
		col_s1 <= s_tdata[5:0];
		row_s1 <= s_tdata[11:6];
		cor_s1 <= s_tdata[13:12];
		sv_s1  <= s_tdata[45:14];
		px_s1  <= 65'($signed(s_tdata[77:46]) * $signed({1'b0, inv_q}));
		py_s1  <= 65'($signed(s_tdata[109:78]) * $signed({1'b0, inv_q}));
	end

	// clamp floor index to 0..size-2
	function automatic logic [5:0] clamp_idx(input logic [32:0] g, input logic [6:0] size,
		input logic [6:0] maxsize);
		logic [6:0] n;
		n = (size > maxsize) ? maxsize : ((size < 7'd2) ? 7'd2 : size);
		n = n - 7'd2;
		if (g[32])                  return 6'd0;
		else if (g[31:0] > 32'(n))  return n[5:0];
		else                        return g[5:0];
	endfunction

	always_comb begin
		req.we_node = vld_s1 && (op_s1 == svi_pkg::OP_WR_NODE);
		req.we_cell = vld_s1 && (op_s1 == svi_pkg::OP_WR_CELL);
		req.rd      = vld_s1 && (op_s1 == svi_pkg::OP_QUERY);
		req.wcol    = col_s1;
		req.wrow    = row_s1;
		req.wcor    = cor_s1;
		req.wdata   = sv_s1;
		req.qcol    = clamp_idx(px_s1[64:32], cols_q, 7'(svi_pkg::MAX_COLS));
		req.qrow    = clamp_idx(py_s1[64:32], rows_q, 7'(svi_pkg::MAX_ROWS));
	end

	// fractions travel alongside the memory read
	always_ff @(posedge clk) begin
		fx_s2 <= px_s1[31:16];
		fy_s2 <= py_s1[31:16];
	end

	svi_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.mode   (layout_q),
		.vld_s2 (vld_s2),
		.v_s2   (v_s2)
	);

	svi_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s2 (vld_s2),
		.v_s2   (v_s2),
		.fx_s2  (fx_s2),
		.fy_s2  (fy_s2),
		.inv    (inv_q),
		.vld_s7 (vld_s7),
		.res_s7 (res_s7)
	);

	svi_ofifo u_ofifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (vld_s7),
		.wdata    (res_s7),
		.pop      (take),
		.nonempty (nonempty),
		.rdata    (head)
	);

	assign m_tvalid = nonempty;
	assign m_tdata  = {head.vel_y, head.vel_x};
	assign m_tuser  = head.sat;

endmodule

// ===== rtl/svi_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module svi_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

// ===== rtl/svi_store.sv =====
// banked streamfunction stores: four node banks by row/col parity, four corner banks
// depends on svi_pkg and svi_ram
module svi_store (
	input  logic                clk,
	input  logic                arst_n,
	input  svi_pkg::store_req_t req,
	input  logic                mode,
	output logic                vld_s2,
	output logic [31:0]         v_s2 [4]
);

	logic [31:0] node_rd [4];
	logic [31:0] cell_rd [4];
	logic        i0_s2, j0_s2, mode_s2;
	logic        wr_ok;

	assign wr_ok = ({1'b0, req.wcol} < 7'(svi_pkg::MAX_COLS)) &&
		({1'b0, req.wrow} < 7'(svi_pkg::MAX_ROWS));

	// one node of the four cell corners lands in each parity bank
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [svi_pkg::IDX_W-1:0] c, r;
		logic [1:0]                bsel;
		assign c = (req.qcol[0] == 1'(b & 1)) ? req.qcol : req.qcol + 6'd1;
		assign r = (req.qrow[0] == 1'(b >> 1)) ? req.qrow : req.qrow + 6'd1;
		assign bsel = 2'(b);

		svi_ram #(.DEPTH(svi_pkg::NODE_BANK_DEPTH), .WIDTH(32)) u_node (
			.clk   (clk),
			.we    (req.we_node && wr_ok && ({req.wrow[0], req.wcol[0]} == bsel)),
			.waddr ({req.wrow[5:1], req.wcol[5:1]}),
			.wdata (req.wdata),
			.re    (req.rd),
			.raddr ({r[5:1], c[5:1]}),
			.rdata (node_rd[b])
		);

		svi_ram #(.DEPTH(svi_pkg::CELL_BANK_DEPTH), .WIDTH(32)) u_cell (
			.clk   (clk),
			.we    (req.we_cell && wr_ok && (req.wcor == bsel)),
			.waddr ({req.wrow, req.wcol}),
			.wdata (req.wdata),
			.re    (req.rd),
			.raddr ({req.qrow, req.qcol}),
			.rdata (cell_rd[b])
		);
	end

	// sideband aligned with read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= req.rd;
		end
	end

	always_ff @(posedge clk) begin
		i0_s2   <= req.qcol[0];
		j0_s2   <= req.qrow[0];
		mode_s2 <= mode;
	end

	// corner order (0,0) (1,0) (1,1) (0,1)
	always_comb begin
		if (mode_s2) begin
			v_s2[0] = cell_rd[0];
			v_s2[1] = cell_rd[1];
			v_s2[2] = cell_rd[2];
			v_s2[3] = cell_rd[3];
		end else begin
			v_s2[0] = node_rd[{j0_s2, i0_s2}];
			v_s2[1] = node_rd[{j0_s2, ~i0_s2}];
			v_s2[2] = node_rd[{~j0_s2, ~i0_s2}];
			v_s2[3] = node_rd[{~j0_s2, i0_s2}];
		end
	end

endmodule

// ===== rtl/svi_calc.sv =====
// bilinear patch gradient, reciprocal scaling and saturation pipeline
// depends on svi_pkg
module svi_calc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_s2,
	input  logic [31:0]        v_s2 [4],
	input  logic [15:0]        fx_s2,
	input  logic [15:0]        fy_s2,
	input  logic [31:0]        inv,
	output logic               vld_s7,
	output svi_pkg::out_word_t res_s7
);

	logic               vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [32:0] a_s3, b_s3, c_s3, d_s3;
	logic [16:0]        fxc_s3, fyc_s3;
	logic [15:0]        fx_s3, fy_s3;
	logic signed [50:0] pa_s4, pb_s4, pc_s4, pd_s4;
	logic signed [51:0] sum_x, sum_y;
	logic signed [35:0] dx_s5, dy_s5;
	logic signed [52:0] xhi_s6, xlo_s6, yhi_s6, ylo_s6;
	logic signed [53:0] sx, sy;
	logic signed [54:0] neg_sx;

	function automatic logic [32:0] sat32(input logic signed [54:0] v);
		if (v > 55'sd2147483647)       return {1'b1, 32'h7fffffff};
		else if (v < -55'sd2147483648) return {1'b1, 32'h80000000};
		else                           return {1'b0, v[31:0]};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
		end else begin
			{vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= {vld_s2, vld_s3, vld_s4, vld_s5, vld_s6};
		end
	end

	// corner differences and fraction complements
	always_ff @(posedge clk) begin
		a_s3   <= $signed({v_s2[1][31], v_s2[1]}) - $signed({v_s2[0][31], v_s2[0]});
		b_s3   <= $signed({v_s2[2][31], v_s2[2]}) - $signed({v_s2[3][31], v_s2[3]});
		c_s3   <= $signed({v_s2[3][31], v_s2[3]}) - $signed({v_s2[0][31], v_s2[0]});
		d_s3   <= $signed({v_s2[2][31], v_s2[2]}) - $signed({v_s2[1][31], v_s2[1]});
		fxc_s3 <= 17'h10000 - {1'b0, fx_s2};
		fyc_s3 <= 17'h10000 - {1'b0, fy_s2};
		fx_s3  <= fx_s2;
		fy_s3  <= fy_s2;
	end

	// weighted differences
	always_ff @(posedge clk) begin
		pa_s4 <= 51'(a_s3 * $signed({1'b0, fyc_s3}));
		pb_s4 <= 51'(b_s3 * $signed({2'b0, fy_s3}));
		pc_s4 <= 51'(c_s3 * $signed({1'b0, fxc_s3}));
		pd_s4 <= 51'(d_s3 * $signed({2'b0, fx_s3}));
	end

	// gradients floored to q16.16
	assign sum_x = 52'(pa_s4) + 52'(pb_s4);
	assign sum_y = 52'(pc_s4) + 52'(pd_s4);

	always_ff @(posedge clk) begin
		dx_s5 <= 36'(sum_x >>> 16);
		dy_s5 <= 36'(sum_y >>> 16);
	end

	// reciprocal scaling split into high and low halves
	always_ff @(posedge clk) begin
		xhi_s6 <= 53'(dx_s5 * $signed({1'b0, inv[31:16]}));
		xlo_s6 <= 53'(dx_s5 * $signed({1'b0, inv[15:0]}));
		yhi_s6 <= 53'(dy_s5 * $signed({1'b0, inv[31:16]}));
		ylo_s6 <= 53'(dy_s5 * $signed({1'b0, inv[15:0]}));
	end

	assign sx     = 54'(xhi_s6) + 54'(xlo_s6 >>> 16);
	assign sy     = 54'(yhi_s6) + 54'(ylo_s6 >>> 16);
	assign neg_sx = -55'(sx);

	// saturate and flag
	always_ff @(posedge clk) begin
		logic [32:0] vx, vy;
		vx = sat32(55'(sy));
		vy = sat32(neg_sx);
		res_s7.vel_x <= vx[31:0];
		res_s7.vel_y <= vy[31:0];
		res_s7.sat   <= vx[32] | vy[32];
	end

endmodule

// ===== rtl/svi_ofifo.sv =====
// result queue between the pipeline and the output channel
// depends on svi_pkg
module svi_ofifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  svi_pkg::out_word_t wdata,
	input  logic               pop,
	output logic               nonempty,
	output svi_pkg::out_word_t rdata
);

	svi_pkg::out_word_t          mem_q [svi_pkg::OFIFO_DEPTH];
	logic [svi_pkg::OFIFO_AW-1:0] wp_q, rp_q;
	logic [svi_pkg::OFIFO_AW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (svi_pkg::OFIFO_AW+1)'(push) - (svi_pkg::OFIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rp_q];

endmodule

// ===== rtl/svi_chk.sv =====
// port-level checker for the streamfunction velocity interpolator
// depends on svi_pkg; bound to streamfunction_velocity_interp
module svi_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata
);

	logic [7:0] pend_q;

	// queries accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(s_tvalid && s_tready && (s_tuser == svi_pkg::OP_QUERY))
				- 8'(m_tvalid && m_tready);
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("output word dropped");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("stalled word changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 8'd0) else $error("result without a query");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> pend_q != 8'd0) else $error("input stalled with nothing pending");

endmodule

bind streamfunction_velocity_interp svi_chk u_svi_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/tb_streamfunction_velocity_interp.sv =====
// self-checking testbench for streamfunction_velocity_interp
// depends on svi_pkg and the rtl of the block; a directed table, then random phases
module tb_streamfunction_velocity_interp;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int NODES = svi_pkg::MAX_COLS * svi_pkg::MAX_ROWS;

	typedef struct {
		logic [31:0] vx;
		logic [31:0] vy;
		logic        sat;
	} vel_t;

	typedef struct {
		logic [1:0]  op;
		logic [5:0]  col;
		logic [5:0]  row;
		logic [1:0]  cor;
		logic [31:0] sv;
		logic [31:0] px;
		logic [31:0] py;
		logic        chk;
		vel_t        vel;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;

	// shadow of the block state
	logic signed [31:0] node_mem [NODES];
	logic signed [31:0] corner_mem [4*NODES];
	bit                 node_ok [NODES];
	bit                 corner_ok [4*NODES];
	logic               mode_q;
	logic [31:0]        inv_q;
	logic [6:0]         cols_q;
	logic [6:0]         rows_q;

	vel_t vel_expected [$];
	int   errors;
	int   src_idle;
	int   dst_idle;
	int   stall_left;
	int   random_items;

	streamfunction_velocity_interp dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// clock and watchdog
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// clamped cell index from a Q32.32 grid coordinate
	function automatic int cell_of(longint g, logic [6:0] size, int maxsize);
		longint fl;
		longint n;
		fl = g >>> 32;
		n = size;
		if (n > maxsize) n = maxsize;
		if (n < 2) n = 2;
		if (fl < 0) return 0;
		if (fl > n - 2) return int'(n - 2);
		return int'(fl);
	endfunction

	function automatic longint grid_coord(logic [31:0] pos);
		return longint'($signed(pos)) * longint'({32'd0, inv_q});
	endfunction

	function automatic logic [31:0] clip32(logic signed [127:0] v, inout logic clip);
		if (v > 128'sd2147483647) begin
			clip = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < -128'sd2147483648) begin
			clip = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// bilinear patch velocity for one query
	function automatic vel_t velocity_of(logic [31:0] px, logic [31:0] py);
		longint gx, gy, fx, fy, dx, dy;
		longint v [4];
		int i, j, a;
		logic signed [127:0] ax, ay, bi, sx, sy;
		vel_t r;
		gx = grid_coord(px);
		gy = grid_coord(py);
		fx = longint'(gx[31:16]);
		fy = longint'(gy[31:16]);
		i = cell_of(gx, cols_q, svi_pkg::MAX_COLS);
		j = cell_of(gy, rows_q, svi_pkg::MAX_ROWS);
		a = j * svi_pkg::MAX_COLS + i;
		if (mode_q) begin
			for (int k = 0; k < 4; k++) v[k] = corner_mem[a*4+k];
		end else begin
			v[0] = node_mem[a];
			v[1] = node_mem[a+1];
			v[2] = node_mem[a+1+svi_pkg::MAX_COLS];
			v[3] = node_mem[a+svi_pkg::MAX_COLS];
		end
		dx = (v[1] - v[0]) * (65536 - fy) + (v[2] - v[3]) * fy;
		dy = (v[3] - v[0]) * (65536 - fx) + (v[2] - v[1]) * fx;
		ax = dx >>> 16;
		ay = dy >>> 16;
		bi = {96'd0, inv_q};
		sx = (ax * bi) >>> 16;
		sy = (ay * bi) >>> 16;
		r.sat = 1'b0;
		r.vx = clip32(sy, r.sat);
		r.vy = clip32(-sx, r.sat);
		return r;
	endfunction

	// update the shadow state for one accepted word
	function automatic void absorb_word(logic [1:0] op, logic [5:0] col, logic [5:0] row,
			logic [1:0] cor, logic [31:0] sv, logic [31:0] px, logic [31:0] py);
		int a;
		a = row * svi_pkg::MAX_COLS + col;
		case (op)
			svi_pkg::OP_WR_NODE: begin
				node_mem[a] = sv;
				node_ok[a] = 1;
			end
			svi_pkg::OP_WR_CELL: begin
				corner_mem[a*4+cor] = sv;
				corner_ok[a*4+cor] = 1;
			end
			svi_pkg::OP_QUERY: vel_expected.insert(vel_expected.size(), velocity_of(px, py));
			default: ;
		endcase
	endfunction

	// offer one input word, idling at random first
	task automatic push_word(logic [1:0] op, logic [5:0] col, logic [5:0] row, logic [1:0] cor,
			logic [31:0] sv, logic [31:0] px, logic [31:0] py);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {2'b00, py, px, sv, cor, row, col};
		s_tuser <= op;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		absorb_word(op, col, row, cor, sv, px, py);
		random_items++;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return $urandom_range(0, 32'h0048_0000) - 32'h0004_0000;
		endcase
	endfunction

	// write any missing entries of the cell a query will read, then query it
	task automatic query_cell(logic [31:0] px, logic [31:0] py);
		int i, j, a;
		int ci [4];
		int cj [4];
		i = cell_of(grid_coord(px), cols_q, svi_pkg::MAX_COLS);
		j = cell_of(grid_coord(py), rows_q, svi_pkg::MAX_ROWS);
		a = j * svi_pkg::MAX_COLS + i;
		ci = '{i, i+1, i+1, i};
		cj = '{j, j, j+1, j+1};
		for (int k = 0; k < 4; k++) begin
			if (mode_q && !corner_ok[a*4+k])
				push_word(svi_pkg::OP_WR_CELL, 6'(i), 6'(j), 2'(k), rand_value(),
					$urandom, $urandom);
			else if (!mode_q && !node_ok[cj[k]*svi_pkg::MAX_COLS+ci[k]])
				push_word(svi_pkg::OP_WR_NODE, 6'(ci[k]), 6'(cj[k]), 2'($urandom),
					rand_value(), $urandom, $urandom);
		end
		push_word(svi_pkg::OP_QUERY, 6'($urandom), 6'($urandom), 2'($urandom), $urandom,
			px, py);
	endtask

	// write all four registers once the block has drained
	task automatic set_regs(logic mode, logic [31:0] inv, logic [6:0] cols, logic [6:0] rows);
		logic [31:0] vals [4];
		s_tvalid <= 1'b0;
		while (vel_expected.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		vals = '{{31'd0, mode}, inv, {25'd0, cols}, {25'd0, rows}};
		for (int r = 0; r < 4; r++) begin
			cfg_index <= r[1:0];
			cfg_data <= vals[r];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		mode_q = mode;
		inv_q = inv;
		cols_q = cols;
		rows_q = rows;
	endtask

	// result side: stalls and checking
	initial begin
		vel_t want;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (vel_expected.size() == 0) begin
					$error("unexpected result word vel_x=%h", m_tdata[31:0]);
					errors++;
				end else begin
					want = vel_expected.pop_front();
					if (m_tdata[31:0] !== want.vx) begin
						$error("vel_x expected %h actual %h", want.vx, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[63:32] !== want.vy) begin
						$error("vel_y expected %h actual %h", want.vy, m_tdata[63:32]);
						errors++;
					end
					if (m_tuser[0] !== want.sat) begin
						$error("saturated expected %b actual %b", want.sat, m_tuser[0]);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(99) >= dst_idle);
		end
	end

	// stimulus
	initial begin
		dir_row_t dir_rows [18];
		vel_t got;
		logic [31:0] cfg_inv [9];
		logic [6:0] cfg_cols [9];
		logic [6:0] cfg_rows [9];
		logic cfg_mode [9];
		int n;
		errors = 0;
		stall_left = 0;
		src_idle = 0;
		dst_idle = 0;
		random_items = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = svi_pkg::REG_LAYOUT;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_NONE;
		mode_q = 1'b0;
		inv_q = 32'd65536;
		cols_q = 7'd64;
		rows_q = 7'd64;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; Psi = x on cell (0,0), extremes on the far corner
		dir_rows = '{
			'{svi_pkg::OP_WR_NODE, 0, 0, 0, 32'h0, 0, 0, 0, '{0, 0, 0}},
			'{svi_pkg::OP_WR_NODE, 1, 0, 0, 32'h0001_0000, 0, 0, 0, '{0, 0, 0}},
			'{svi_pkg::OP_WR_NODE, 0, 1, 0, 32'h0, 0, 0, 0, '{0, 0, 0}},
			'{svi_pkg::OP_WR_NODE, 1, 1, 0, 32'h0001_0000, 0, 0, 0, '{0, 0, 0}},
			'{svi_pkg::OP_QUERY, 0, 0, 0, 0, 32'h0, 32'h0, 1, '{32'h0, 32'hFFFF_0000, 0}},
			'{svi_pkg::OP_QUERY, 0, 0, 0, 0, 32'h0000_8000, 32'h0, 1,
				'{32'h0, 32'hFFFF_0000, 0}},
			'{svi_pkg::OP_WR_NODE, 62, 62, 3, 32'h8000_0000, 0, 0, 0, '{0, 0, 0}},
			'{svi_pkg::OP_WR_NODE, 63, 62, 0, 32'h7FFF_FFFF, 0, 0, 0, '{0, 0, 0}},
			'{svi_pkg::OP_WR_NODE, 62, 63, 0, 32'h8000_0000, 0, 0, 0, '{0, 0, 0}},
			'{svi_pkg::OP_WR_NODE, 63, 63, 3, 32'h7FFF_FFFF, '1, '1, 0, '{0, 0, 0}},
			'{svi_pkg::OP_QUERY, 63, 63, 3, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
				'{0, 0, 0}},
			'{svi_pkg::OP_QUERY, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 1,
				'{32'h0, 32'hFFFF_0000, 0}},
			'{OP_NONE, 63, 63, 3, '1, '1, '1, 0, '{0, 0, 0}},
			'{svi_pkg::OP_WR_CELL, 63, 63, 0, 32'hFFFF_FFFF, '1, '1, 0, '{0, 0, 0}},
			'{svi_pkg::OP_WR_CELL, 63, 63, 1, 32'h0000_0001, 0, 0, 0, '{0, 0, 0}},
			'{svi_pkg::OP_WR_CELL, 63, 63, 2, 32'h7FFF_FFFF, 0, 0, 0, '{0, 0, 0}},
			'{svi_pkg::OP_WR_CELL, 63, 63, 3, 32'h8000_0000, 0, 0, 0, '{0, 0, 0}},
			'{svi_pkg::OP_QUERY, 5, 9, 1, 32'h1234_5678, 32'h0000_4000, 32'h0000_C000, 0,
				'{0, 0, 0}}
		};
		foreach (dir_rows[r]) begin
			n = vel_expected.size();
			push_word(dir_rows[r].op, dir_rows[r].col, dir_rows[r].row, dir_rows[r].cor,
				dir_rows[r].sv, dir_rows[r].px, dir_rows[r].py);
			if (dir_rows[r].chk) begin
				got = vel_expected[n];
				if (got != dir_rows[r].vel) begin
					$error("table row %0d vel expected %h/%h/%b predicted %h/%h/%b", r,
						dir_rows[r].vel.vx, dir_rows[r].vel.vy, dir_rows[r].vel.sat,
						got.vx, got.vy, got.sat);
					errors++;
				end
			end
		end

		// register settings per phase, extremes first
		cfg_mode = '{1, 0, 1, 0, 1, 0, 1, 0, 1};
		cfg_inv = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0000_8000,
			32'h0004_0000, 32'h0001_8000, 32'h0000_0400, 32'h0010_0000};
		cfg_cols = '{7'd64, 7'd64, 7'd2, 7'd127, 7'd10, 7'd0, 7'd33, 7'd64, 7'd1};
		cfg_rows = '{7'd64, 7'd17, 7'd2, 7'd0, 7'd33, 7'd100, 7'd5, 7'd2, 7'd64};

		// every accepted word counts toward the phase budget
		random_items = 0;
		for (int p = 0; p < 9; p++) begin
			set_regs(cfg_mode[p], cfg_inv[p], cfg_cols[p], cfg_rows[p]);
			src_idle = (p < 3) ? 21 : (p < 6) ? 80 : 0;
			dst_idle = (p < 3) ? 80 : (p < 6) ? 21 : 0;
			if (p == 6) stall_left = 400;
			n = random_items + 205;
			while (random_items < n) begin
				case ($urandom_range(19))
					0: push_word(OP_NONE, 6'($urandom), 6'($urandom), 2'($urandom),
						$urandom, $urandom, $urandom);
					1, 2, 3, 4: push_word($urandom_range(1) ? svi_pkg::OP_WR_CELL
						: svi_pkg::OP_WR_NODE, 6'($urandom), 6'($urandom), 2'($urandom),
						rand_value(), $urandom, $urandom);
					default: query_cell(rand_pos(), rand_pos());
				endcase
			end
		end

		s_tvalid <= 1'b0;
		while (vel_expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
